[src/pdshp_pkg.sv]
// ============================================================================
// Phase distortion shaper package
// Shared widths, register indexes, operation codes and reset values.
// ============================================================================
package pdshp_pkg;

    localparam int DATA_W  = 32;
    localparam int CFG_W   = 31;
    localparam int ADDR_W  = 2;
    localparam int FRAC_W  = 16;

    // Q16.16 value of 1.0.
    localparam logic [DATA_W-1:0] FIX_ONE = 32'h0001_0000;

    // Configuration register indexes.
    localparam logic [ADDR_W-1:0] REG_PHASE_FACTOR  = 2'd0;
    localparam logic [ADDR_W-1:0] REG_PHASE_SHIFT   = 2'd1;
    localparam logic [ADDR_W-1:0] REG_BEND_AMOUNT   = 2'd2;
    localparam logic [ADDR_W-1:0] REG_COMPRESS_GAIN = 2'd3;

    // Operation codes.
    localparam logic OP_PHASE = 1'b0;
    localparam logic OP_SHAPE = 1'b1;

    // Reset values and legal bounds of the registers.
    localparam logic [17:0] FACTOR_RESET   = 18'h10000;
    localparam logic [17:0] FACTOR_MIN     = 18'h08000;
    localparam logic [17:0] FACTOR_MAX     = 18'h20000;
    localparam logic [30:0] COMPRESS_RESET = 31'h0001_0000;

endpackage

[src/phase_distortion_shaper.sv]
// ============================================================================
// Phase distortion shaper
// Q16.16 phase warp and curve shaper for an oscillator, seven-stage pipeline.
// ============================================================================
//
//  Channel   Ports                                      Handshake
//  --------  -----------------------------------------  ------------------------
//  request   start, busy, op, sample_value              taken when start & !busy
//  result    result_valid, result_value                 one-cycle strobe
//  config    cfg_we, cfg_addr, cfg_wdata                taken when cfg_we
//
//  Every request gives one result, and a new request can be taken in every
//  cycle; busy is therefore always low. The latency is set by the multiplier
//  chain of the shape path: square, blend products, blend sum, gain product and
//  final rounding each own a stage.
//  Reset clears the valid bits and loads the register reset values.
//  The result side cannot stall, so the pipeline advances on every clock.
//
// The phase operation scales the input by phase_factor, rounds to Q16.16 and
// adds the shift; only the low 16 bits survive the wrap. Because the offset
// used for a negative shift is shift + 1.0, its low 16 bits equal those of the
// shift itself, so the shift's low half is added directly. Only the low 32 bits
// of the product are needed for the same reason.
//
// The shape operation squares |y| (y = x, or 1.0 - x for a negative bend),
// blends x and the curve with weights (1.0 - |bend|) and |bend|, multiplies by
// compress_gain, rounds and clamps to 1.0. The blend weights always add up to
// 1.0, so the blend never leaves the 32-bit range and the end points of the
// bend range need no special handling.
// ============================================================================
module phase_distortion_shaper
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                op,
    input  logic signed [pdshp_pkg::DATA_W-1:0] sample_value,
    output logic                                result_valid,
    output logic signed [pdshp_pkg::DATA_W-1:0] result_value,
    input  logic                                cfg_we,
    input  logic        [pdshp_pkg::ADDR_W-1:0] cfg_addr,
    input  logic        [pdshp_pkg::CFG_W-1:0]  cfg_wdata
);

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic        [17:0] factor_reg;
    logic signed [17:0] shift_reg;
    logic signed [17:0] bend_reg;
    logic        [30:0] compress_reg;

    logic signed [17:0] wdata_s18;
    logic               factor_ok;
    logic               s18_ok;
    logic               compress_ok;

    assign wdata_s18   = $signed(cfg_wdata[17:0]);
    assign factor_ok   = (cfg_wdata[17:0] >= pdshp_pkg::FACTOR_MIN) &&
                         (cfg_wdata[17:0] <= pdshp_pkg::FACTOR_MAX);
    assign s18_ok      = (wdata_s18 >= -18'sd65536) && (wdata_s18 <= 18'sd65536);
    assign compress_ok = |cfg_wdata[30:16];

    // Writes outside the legal range leave the register unchanged.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg   <= pdshp_pkg::FACTOR_RESET;
            shift_reg    <= '0;
            bend_reg     <= '0;
            compress_reg <= pdshp_pkg::COMPRESS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                pdshp_pkg::REG_PHASE_FACTOR:
                begin
                    if (factor_ok)
                    begin
                        factor_reg <= cfg_wdata[17:0];
                    end
                end
                pdshp_pkg::REG_PHASE_SHIFT:
                begin
                    if (s18_ok)
                    begin
                        shift_reg <= wdata_s18;
                    end
                end
                pdshp_pkg::REG_BEND_AMOUNT:
                begin
                    if (s18_ok)
                    begin
                        bend_reg <= wdata_s18;
                    end
                end
                pdshp_pkg::REG_COMPRESS_GAIN:
                begin
                    if (compress_ok)
                    begin
                        compress_reg <= cfg_wdata;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // The pipeline never holds off a request.
    assign busy = 1'b0;

    logic take;
    assign take = start && !busy;

    // Bend sign and magnitude, shared by the curve and blend stages.
    logic        bend_neg;
    logic [17:0] bend_abs;
    logic [16:0] w_curve;
    logic [16:0] w_input;

    assign bend_neg = bend_reg[17];
    assign bend_abs = bend_neg ? 18'(-bend_reg) : bend_reg;
    assign w_curve  = bend_abs[16:0];
    assign w_input  = 17'h10000 - w_curve;

    // ------------------------------------------------------------------
    // Valid bits, one per stage.
    // ------------------------------------------------------------------
    logic [6:0] valid_reg;
    logic [6:0] valid_next;

    assign valid_next = {valid_reg[5:0], take};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: phase product, and magnitude of the value to be squared.
    // ------------------------------------------------------------------
    logic signed [50:0] phase_prod;
    logic signed [33:0] sq_arg;
    logic signed [33:0] sq_arg_abs;

    assign phase_prod = 51'(sample_value) * 51'($signed({1'b0, factor_reg}));
    assign sq_arg     = bend_neg ? (34'sd65536 - 34'(sample_value)) : 34'(sample_value);
    assign sq_arg_abs = sq_arg[33] ? -sq_arg : sq_arg;

    logic               s1_op_reg;
    logic signed [31:0] s1_x_reg;
    logic        [31:0] s1_pprod_reg;
    logic        [23:0] s1_mag_reg;
    logic               s1_big_reg;

    always_ff @(posedge clk)
    begin
        s1_op_reg    <= op;
        s1_x_reg     <= sample_value;
        s1_pprod_reg <= phase_prod[31:0];
        s1_mag_reg   <= sq_arg_abs[23:0];
        s1_big_reg   <= |sq_arg_abs[32:24];
    end

    // ------------------------------------------------------------------
    // Stage 2: wrapped phase result, and the square of the magnitude.
    // A negative product is decremented before rounding.
    // ------------------------------------------------------------------
    logic [31:0] pprod_dec;
    logic [15:0] phase_next;

    assign pprod_dec  = s1_pprod_reg - {31'd0, s1_x_reg[31]};
    assign phase_next = pprod_dec[31:16] + {15'd0, pprod_dec[15]} + shift_reg[15:0];

    logic               s2_op_reg;
    logic signed [31:0] s2_x_reg;
    logic        [15:0] s2_phase_reg;
    logic        [47:0] s2_sq_reg;
    logic               s2_big_reg;

    always_ff @(posedge clk)
    begin
        s2_op_reg    <= s1_op_reg;
        s2_x_reg     <= s1_x_reg;
        s2_phase_reg <= phase_next;
        s2_sq_reg    <= 48'(s1_mag_reg) * 48'(s1_mag_reg);
        s2_big_reg   <= s1_big_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: two rounding steps of the square, saturation, curve select.
    // ------------------------------------------------------------------
    logic        [48:0] sq_round1;
    logic        [43:0] sq_round2;
    logic        [30:0] sq_sat;
    logic signed [31:0] curve_next;

    assign sq_round1  = {1'b0, s2_sq_reg} + 49'd32;
    assign sq_round2  = {1'b0, sq_round1[48:6]} + 44'd512;
    assign sq_sat     = (s2_big_reg || (|sq_round2[43:41])) ? 31'h7FFF_FFFF
                                                            : sq_round2[40:10];
    assign curve_next = bend_neg ? (32'sd65536 - $signed({1'b0, sq_sat}))
                                 : $signed({1'b0, sq_sat});

    logic               s3_op_reg;
    logic signed [31:0] s3_x_reg;
    logic        [15:0] s3_phase_reg;
    logic signed [31:0] s3_curve_reg;

    always_ff @(posedge clk)
    begin
        s3_op_reg    <= s2_op_reg;
        s3_x_reg     <= s2_x_reg;
        s3_phase_reg <= s2_phase_reg;
        s3_curve_reg <= curve_next;
    end

    // ------------------------------------------------------------------
    // Stage 4: weighted products of input and curve.
    // ------------------------------------------------------------------
    logic               s4_op_reg;
    logic        [15:0] s4_phase_reg;
    logic signed [48:0] s4_px_reg;
    logic signed [48:0] s4_pe_reg;

    always_ff @(posedge clk)
    begin
        s4_op_reg    <= s3_op_reg;
        s4_phase_reg <= s3_phase_reg;
        s4_px_reg    <= 49'(s3_x_reg) * 49'($signed({1'b0, w_input}));
        s4_pe_reg    <= 49'(s3_curve_reg) * 49'($signed({1'b0, w_curve}));
    end

    // ------------------------------------------------------------------
    // Stage 5: blend sum and floor shift.
    // ------------------------------------------------------------------
    logic signed [49:0] blend_sum;

    assign blend_sum = 50'(s4_px_reg) + 50'(s4_pe_reg);

    logic               s5_op_reg;
    logic        [15:0] s5_phase_reg;
    logic signed [31:0] s5_blend_reg;

    always_ff @(posedge clk)
    begin
        s5_op_reg    <= s4_op_reg;
        s5_phase_reg <= s4_phase_reg;
        s5_blend_reg <= blend_sum[47:16];
    end

    // ------------------------------------------------------------------
    // Stage 6: gain product.
    // ------------------------------------------------------------------
    logic               s6_op_reg;
    logic        [15:0] s6_phase_reg;
    logic signed [62:0] s6_gain_reg;

    always_ff @(posedge clk)
    begin
        s6_op_reg    <= s5_op_reg;
        s6_phase_reg <= s5_phase_reg;
        s6_gain_reg  <= 63'(s5_blend_reg) * 63'($signed({1'b0, compress_reg}));
    end

    // ------------------------------------------------------------------
    // Stage 7: rounding of the gain product, clamp, result select.
    // ------------------------------------------------------------------
    logic        [62:0] gain_dec;
    logic signed [47:0] gain_round;
    logic signed [31:0] shaped;
    logic signed [31:0] result_next;

    assign gain_dec   = s6_gain_reg - {62'd0, s6_gain_reg[62]};
    assign gain_round = $signed({gain_dec[62], gain_dec[62:16]}) +
                        $signed({47'd0, gain_dec[15]});

    always_comb
    begin
        priority if (gain_round > 48'sd65536)
        begin
            shaped = pdshp_pkg::FIX_ONE;
        end
        else if (gain_round < -48'sd2147483648)
        begin
            shaped = 32'sh8000_0000;
        end
        else
        begin
            shaped = gain_round[31:0];
        end
    end

    assign result_next = (s6_op_reg == pdshp_pkg::OP_PHASE) ? {16'd0, s6_phase_reg} : shaped;

    logic signed [31:0] result_value_reg;

    always_ff @(posedge clk)
    begin
        result_value_reg <= result_next;
    end

    assign result_valid = valid_reg[6];
    assign result_value = result_value_reg;

endmodule

[src/pdshp_checker.sv]
// ============================================================================
// Phase distortion shaper checker
// Port-level checks of latency and result range, bound to the top level.
// ============================================================================
module pdshp_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                op,
    input logic                                result_valid,
    input logic signed [pdshp_pkg::DATA_W-1:0] result_value
);

    // Every request is answered by a result strobe.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##7 result_valid)
        else $error("request was not answered after seven cycles");

    // No result appears without a matching earlier request.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start && !busy, 7))
        else $error("result strobe without a matching request");

    // A phase result is wrapped to sixteen fraction bits.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && ($past(op, 7) == pdshp_pkg::OP_PHASE))
            |-> (result_value[31:16] == 16'd0))
        else $error("phase result has bits above the fraction");

    // Shaped results never exceed 1.0.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_value <= 32'sh0001_0000))
        else $error("result exceeds 1.0");

endmodule

bind phase_distortion_shaper pdshp_checker u_pdshp_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .op           (op),
    .result_valid (result_valid),
    .result_value (result_value)
);
